>>> rtl/msps_pkg.sv
// Shared types, constants and table lookups for the stepper position sequencer.
`timescale 1ns / 1ps
package msps_pkg;

	localparam int OPCODE_W   = 2;
	localparam int MOTOR_W    = 3;
	localparam int TARGET_W   = 16;
	localparam int COIL_W     = 4;
	localparam int PHASE_W    = 3;
	localparam int POS_OUT_W  = 16;
	localparam int COIL_TBL_W = 32;
	localparam int NEXT_TBL_W = 24;
	localparam int UPPER_W    = 5;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;
	localparam int QUEUE_DEPTH = 2;
	localparam int QUEUE_PTR_W = 1;

	localparam logic [OPCODE_W-1:0] OP_TICK       = 2'd0;
	localparam logic [OPCODE_W-1:0] OP_SET_TARGET = 2'd1;
	localparam logic [OPCODE_W-1:0] OP_CALIBRATE  = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_COIL_PATTERN = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_UP_NEXT      = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_DOWN_NEXT    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_STOP_NEXT    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_UPPER_MASK   = 3'd4;

	localparam logic [COIL_TBL_W-1:0] COIL_RESET = 32'd2563007025;
	localparam logic [NEXT_TBL_W-1:0] UP_RESET   = 24'd2054353;
	localparam logic [NEXT_TBL_W-1:0] DOWN_RESET = 24'd14038087;
	localparam logic [NEXT_TBL_W-1:0] STOP_RESET = 24'd16434824;
	localparam logic [UPPER_W-1:0]    UPPER_RESET = 5'd0;

	typedef enum logic [1:0] {
		CMD_TICK,
		CMD_SET_TARGET,
		CMD_CALIBRATE
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t                   kind;
		logic [MOTOR_W-1:0]          motor;
		logic signed [TARGET_W-1:0]  target;
	} cmd_t;

	typedef struct packed {
		logic [COIL_TBL_W-1:0] coil_pattern_table;
		logic [NEXT_TBL_W-1:0] up_next_table;
		logic [NEXT_TBL_W-1:0] down_next_table;
		logic [NEXT_TBL_W-1:0] stop_next_table;
		logic [UPPER_W-1:0]    upper_half_mask;
	} cfg_t;

	function automatic logic [PHASE_W-1:0] next_phase(input logic [NEXT_TBL_W-1:0] tbl,
			input logic [PHASE_W-1:0] st);
		return tbl[st*PHASE_W +: PHASE_W];
	endfunction

	function automatic logic [COIL_W-1:0] coil_of(input logic [COIL_TBL_W-1:0] tbl,
			input logic [PHASE_W-1:0] st);
		return tbl[st*COIL_W +: COIL_W];
	endfunction

endpackage

>>> rtl/msps_cmd_if.sv
// Command channel: opcode, motor select and target position.
`timescale 1ns / 1ps
interface msps_cmd_if;
	logic                                     valid;
	logic                                     ready;
	logic [msps_pkg::OPCODE_W-1:0]            opcode;
	logic [msps_pkg::MOTOR_W-1:0]             motor_select;
	logic signed [msps_pkg::TARGET_W-1:0]     target_position;

	modport source (output valid, opcode, motor_select, target_position, input ready);
	modport sink (input valid, opcode, motor_select, target_position, output ready);
endinterface

>>> rtl/msps_res_if.sv
// Result channel: per-motor coil pattern and position.
`timescale 1ns / 1ps
interface msps_res_if;
	logic                                     valid;
	logic                                     ready;
	logic [msps_pkg::MOTOR_W-1:0]             motor_number;
	logic [msps_pkg::COIL_W-1:0]              coil_pattern;
	logic                                     upper_nibble;
	logic signed [msps_pkg::POS_OUT_W-1:0]    step_position;
	logic                                     calibrated;
	logic                                     last_motor;

	modport source (output valid, motor_number, coil_pattern, upper_nibble, step_position,
		calibrated, last_motor, input ready);
	modport sink (input valid, motor_number, coil_pattern, upper_nibble, step_position,
		calibrated, last_motor, output ready);
endinterface

>>> rtl/msps_front.sv
// Front end: accept items, classify them and drop unknown opcodes and out-of-range motors.
`timescale 1ns / 1ps
module msps_front #(
	parameter int MOTOR_COUNT = 5
) (
	msps_cmd_if.sink          cmd,
	input  logic              queue_full,
	output logic              push,
	output msps_pkg::cmd_t    push_cmd
);
	import msps_pkg::*;

	localparam logic [MOTOR_W:0] MOTOR_LIMIT = (MOTOR_W+1)'(MOTOR_COUNT);

	logic motor_ok;
	logic legal;

	assign cmd.ready = !queue_full;
	assign motor_ok  = {1'b0, cmd.motor_select} < MOTOR_LIMIT;

	always_comb begin
		push_cmd.motor  = cmd.motor_select;
		push_cmd.target = cmd.target_position;
		push_cmd.kind   = CMD_TICK;
		legal           = 1'b0;
		case (cmd.opcode)
			OP_TICK: begin
				push_cmd.kind = CMD_TICK;
				legal         = 1'b1;
			end
			OP_SET_TARGET: begin
				push_cmd.kind = CMD_SET_TARGET;
				legal         = motor_ok;
			end
			OP_CALIBRATE: begin
				push_cmd.kind = CMD_CALIBRATE;
				legal         = motor_ok;
			end
			default: begin
				legal = 1'b0;
			end
		endcase
	end

	assign push = cmd.valid && !queue_full && legal;

endmodule

>>> rtl/msps_cmd_fifo.sv
// Short command queue between the front end and the motor stepper.
`timescale 1ns / 1ps
module msps_cmd_fifo (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  msps_pkg::cmd_t    push_cmd,
	output logic              full,
	output logic              head_valid,
	output msps_pkg::cmd_t    head_cmd,
	input  logic              pop
);
	import msps_pkg::*;

	cmd_t                   entry_q [QUEUE_DEPTH];
	logic [QUEUE_PTR_W-1:0] wr_ptr_q;
	logic [QUEUE_PTR_W-1:0] rd_ptr_q;
	logic [QUEUE_PTR_W:0]   count_q;
	logic                   do_push;
	logic                   do_pop;

	assign full       = count_q == (QUEUE_PTR_W+1)'(QUEUE_DEPTH);
	assign head_valid = count_q != '0;
	assign head_cmd   = entry_q[rd_ptr_q];
	assign do_push    = push && !full;
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

>>> rtl/msps_back.sv
// Back end: apply commands and step one motor per cycle on a tick while results are taken.
`timescale 1ns / 1ps
module msps_back #(
	parameter int MOTOR_COUNT   = 5,
	parameter int PHASE_STATES  = 8,
	parameter int POSITION_BITS = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cmd_valid,
	input  msps_pkg::cmd_t    cmd,
	output logic              cmd_pop,
	input  msps_pkg::cfg_t    cfg,
	msps_res_if.source        res
);
	import msps_pkg::*;

	localparam int IW = (MOTOR_COUNT > 1) ? $clog2(MOTOR_COUNT) : 1;
	localparam logic [IW-1:0]      LAST_IDX    = IW'(MOTOR_COUNT - 1);
	localparam logic [PHASE_W:0]   PHASE_LIMIT = (PHASE_W+1)'(PHASE_STATES);
	localparam logic [PHASE_W-1:0] PHASE_TOP   = PHASE_W'(PHASE_STATES - 1);

	logic [POSITION_BITS-1:0] pos_q   [MOTOR_COUNT];
	logic [POSITION_BITS-1:0] tgt_q   [MOTOR_COUNT];
	logic [PHASE_W-1:0]       phase_q [MOTOR_COUNT];
	logic [MOTOR_COUNT-1:0]   calp_q;
	logic [IW-1:0]            idx_q;

	logic                     res_valid_q;
	logic [MOTOR_W-1:0]       res_motor_q;
	logic [COIL_W-1:0]        res_coil_q;
	logic                     res_upper_q;
	logic [POS_OUT_W-1:0]     res_pos_q;
	logic                     res_cal_q;
	logic                     res_last_q;

	logic [POSITION_BITS-1:0] cur_pos;
	logic [POSITION_BITS-1:0] cur_tgt;
	logic                     above;
	logic                     below;
	logic [NEXT_TBL_W-1:0]    tbl;
	logic [PHASE_W-1:0]       raw_next;
	logic [PHASE_W-1:0]       nxt;
	logic                     cal_hit;
	logic [POSITION_BITS-1:0] new_pos;
	logic [7:0]               mask_ext;
	logic [MOTOR_W-1:0]       motor_num;
	logic [IW-1:0]            sel;
	logic                     advance;
	logic                     step;
	logic                     last;

	assign cur_pos   = pos_q[idx_q];
	assign cur_tgt   = tgt_q[idx_q];
	assign above     = $signed(cur_pos) > $signed(cur_tgt);
	assign below     = $signed(cur_pos) < $signed(cur_tgt);
	assign tbl       = above ? cfg.down_next_table :
		(below ? cfg.up_next_table : cfg.stop_next_table);
	assign raw_next  = next_phase(tbl, phase_q[idx_q]);
	assign nxt       = ({1'b0, raw_next} >= PHASE_LIMIT) ? PHASE_TOP : raw_next;
	assign cal_hit   = !above && !below && calp_q[idx_q];
	assign mask_ext  = 8'(cfg.upper_half_mask);
	assign motor_num = MOTOR_W'(idx_q);
	assign sel       = cmd.motor[IW-1:0];

	always_comb begin
		if (above) begin
			new_pos = cur_pos - 1'b1;
		end else if (below) begin
			new_pos = cur_pos + 1'b1;
		end else if (cal_hit) begin
			new_pos = '0;
		end else begin
			new_pos = cur_pos;
		end
	end

	assign advance = !res_valid_q || res.ready;
	assign last    = idx_q == LAST_IDX;
	assign step    = cmd_valid && (cmd.kind == CMD_TICK) && advance;
	assign cmd_pop = cmd_valid && ((cmd.kind != CMD_TICK) || (advance && last));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int m = 0; m < MOTOR_COUNT; m++) begin
				pos_q[m]   <= '0;
				tgt_q[m]   <= '0;
				phase_q[m] <= '0;
			end
			calp_q      <= '0;
			idx_q       <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (step) begin
				pos_q[idx_q]   <= new_pos;
				phase_q[idx_q] <= nxt;
				if (cal_hit) begin
					tgt_q[idx_q]  <= '0;
					calp_q[idx_q] <= 1'b0;
				end
				idx_q       <= last ? '0 : idx_q + 1'b1;
				res_valid_q <= 1'b1;
			end else if (res.ready) begin
				res_valid_q <= 1'b0;
			end
			if (cmd_valid && (cmd.kind == CMD_SET_TARGET)) begin
				tgt_q[sel] <= POSITION_BITS'(cmd.target);
			end
			if (cmd_valid && (cmd.kind == CMD_CALIBRATE)) begin
				calp_q[sel] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			res_motor_q <= motor_num;
			res_coil_q  <= coil_of(cfg.coil_pattern_table, nxt);
			res_upper_q <= mask_ext[motor_num];
			res_pos_q   <= POS_OUT_W'(new_pos);
			res_cal_q   <= cal_hit;
			res_last_q  <= last;
		end
	end

	assign res.valid         = res_valid_q;
	assign res.motor_number  = res_motor_q;
	assign res.coil_pattern  = res_coil_q;
	assign res.upper_nibble  = res_upper_q;
	assign res.step_position = res_pos_q;
	assign res.calibrated    = res_cal_q;
	assign res.last_motor    = res_last_q;

endmodule

>>> rtl/multi_stepper_position_sequencer.sv
// Top level: config registers, front end, command queue and motor stepper.
// Flow: an accepted tick is written into the command queue; each result is registered.
// Steps one motor per cycle through the shared step unit while the result channel
// is not stalled; set-target and calibration commands apply as they leave the queue.
// Reset: positions, targets, phases and pending flags clear; tables take defaults.
`timescale 1ns / 1ps
module multi_stepper_position_sequencer #(
	parameter int MOTOR_COUNT   = 5,
	parameter int PHASE_STATES  = 8,
	parameter int POSITION_BITS = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	msps_cmd_if.sink                          cmd,
	msps_res_if.source                        res,
	input  logic                              cfg_we,
	input  logic [msps_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [msps_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
	import msps_pkg::*;

	cfg_t cfg_q;
	logic push;
	cmd_t push_cmd;
	logic queue_full;
	logic head_valid;
	cmd_t head_cmd;
	logic pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.coil_pattern_table <= COIL_RESET;
			cfg_q.up_next_table      <= UP_RESET;
			cfg_q.down_next_table    <= DOWN_RESET;
			cfg_q.stop_next_table    <= STOP_RESET;
			cfg_q.upper_half_mask    <= UPPER_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_COIL_PATTERN: cfg_q.coil_pattern_table <= cfg_wdata;
				CFG_UP_NEXT:      cfg_q.up_next_table      <= cfg_wdata[NEXT_TBL_W-1:0];
				CFG_DOWN_NEXT:    cfg_q.down_next_table    <= cfg_wdata[NEXT_TBL_W-1:0];
				CFG_STOP_NEXT:    cfg_q.stop_next_table    <= cfg_wdata[NEXT_TBL_W-1:0];
				CFG_UPPER_MASK:   cfg_q.upper_half_mask    <= cfg_wdata[UPPER_W-1:0];
				default: begin
				end
			endcase
		end
	end

	msps_front #(
		.MOTOR_COUNT (MOTOR_COUNT)
	) u_front (
		.cmd        (cmd),
		.queue_full (queue_full),
		.push       (push),
		.push_cmd   (push_cmd)
	);

	msps_cmd_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_cmd   (push_cmd),
		.full       (queue_full),
		.head_valid (head_valid),
		.head_cmd   (head_cmd),
		.pop        (pop)
	);

	msps_back #(
		.MOTOR_COUNT   (MOTOR_COUNT),
		.PHASE_STATES  (PHASE_STATES),
		.POSITION_BITS (POSITION_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (head_valid),
		.cmd       (head_cmd),
		.cmd_pop   (pop),
		.cfg       (cfg_q),
		.res       (res)
	);

endmodule
